>>> sv/cross_neighbour_sum_stencil_unit_defines.svh
// assertion macros for the port level checker file
`ifndef CROSS_NEIGHBOUR_SUM_STENCIL_UNIT_DEFINES_SVH
`define CROSS_NEIGHBOUR_SUM_STENCIL_UNIT_DEFINES_SVH

// clocked check, switched off while reset is active
`define CNSU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define CNSU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/cnsu_pkg.sv
// shared types and constants of the cross neighbour sum stencil
package cnsu_pkg;

    localparam int PIX_W   = 32;
    localparam int CFG_W   = 11;
    localparam int OUT_W   = 10;
    // column width carried between front and back, enough for the largest image
    localparam int COORD_W = 12;

    typedef struct packed {
        logic emit_up;
        logic up_copy;
        logic emit_copy;
        logic eoi;
    } cls_t;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [COORD_W-1:0] col;
        logic [OUT_W-1:0]   row_up;
        logic [OUT_W-1:0]   row_cur;
        cls_t               cls;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last_of_run;
        logic             end_of_image;
    } res_t;

endpackage

>>> sv/cnsu_ram.sv
// generic single write port ram with registered read
module cnsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/cnsu_fifo.sv
// small flop based queue
module cnsu_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/cnsu_front.sv
// front end: size register, raster counters and classification of each pixel
module cnsu_front #(
    parameter int MAX_IMAGE_SIZE = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [cnsu_pkg::PIX_W-1:0] pixel_value,
    input  logic                       cfg_we,
    input  logic [cnsu_pkg::CFG_W-1:0] image_size,
    input  logic                       q_full,
    output logic                       q_push,
    output cnsu_pkg::item_t            q_item
);

    localparam int AW = $clog2(MAX_IMAGE_SIZE);
    localparam int NW = $clog2(MAX_IMAGE_SIZE + 1);

    logic [NW-1:0] size_reg, size_next;
    logic [AW-1:0] row_reg, row_next;
    logic [AW-1:0] col_reg, col_next;
    logic [NW-1:0] last_idx;
    logic          col_last;
    logic          row_last;
    logic [31:0]   row_wide;
    logic [31:0]   row_up_wide;

    function automatic logic [NW-1:0] clamp_size(input logic [cnsu_pkg::CFG_W-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        if (w < 32'd3)
        begin
            w = 32'd3;
        end
        else if (w > 32'(MAX_IMAGE_SIZE))
        begin
            w = 32'(MAX_IMAGE_SIZE);
        end
        return w[NW-1:0];
    endfunction

    assign full     = q_full;
    assign q_push   = push && !q_full;
    assign last_idx = size_reg - NW'(1);
    assign col_last = (NW'(col_reg) == last_idx);
    assign row_last = (NW'(row_reg) == last_idx);

    assign row_wide    = 32'(row_reg);
    assign row_up_wide = row_wide - 32'd1;

    always_comb
    begin
        q_item.x             = pixel_value;
        q_item.col           = cnsu_pkg::COORD_W'(col_reg);
        q_item.row_up        = row_up_wide[cnsu_pkg::OUT_W-1:0];
        q_item.row_cur       = row_wide[cnsu_pkg::OUT_W-1:0];
        q_item.cls.emit_up   = (row_reg != '0);
        q_item.cls.up_copy   = (row_reg == AW'(1)) || (col_reg == '0) || col_last;
        q_item.cls.emit_copy = row_last;
        q_item.cls.eoi       = row_last && col_last;
    end

    always_comb
    begin
        size_next = size_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (cfg_we)
        begin
            size_next = clamp_size(image_size);
            row_next  = '0;
            col_next  = '0;
        end
        else if (q_push)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + AW'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= clamp_size(cnsu_pkg::CFG_W'(256));
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            size_reg <= size_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

endmodule

>>> sv/cnsu_back.sv
// back end: line stores, neighbour sum and result sequencing
module cnsu_back #(
    parameter int MAX_IMAGE_SIZE = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  cnsu_pkg::item_t q_item,
    output logic            q_pop,
    input  logic            res_full,
    output logic            res_push,
    output cnsu_pkg::res_t  res_data
);

    localparam int AW = $clog2(MAX_IMAGE_SIZE);

    cnsu_pkg::item_t            item_reg;
    logic                       valid_reg, valid_next;
    logic                       phase_reg, phase_next;
    logic [cnsu_pkg::PIX_W-1:0] left_hold_reg;

    logic [cnsu_pkg::PIX_W-1:0] above;
    logic [cnsu_pkg::PIX_W-1:0] up2;
    logic [cnsu_pkg::PIX_W-1:0] right;
    logic [cnsu_pkg::PIX_W-1:0] sum;
    logic [cnsu_pkg::PIX_W-1:0] up_value;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              rd_addr_right;
    logic [AW-1:0]              wr_addr;
    logic                       need_up;
    logic                       need_copy;
    logic                       has_res;
    logic                       res_is_last;
    logic                       retire;

    assign rd_addr       = q_item.col[AW-1:0];
    assign rd_addr_right = q_item.col[AW-1:0] + AW'(1);
    assign wr_addr       = item_reg.col[AW-1:0];

    // row above, two rows above, and the row above one column to the right
    cnsu_ram #(.WIDTH(cnsu_pkg::PIX_W), .DEPTH(MAX_IMAGE_SIZE)) u_newer
    (
        .clk   (clk),
        .we    (retire),
        .waddr (wr_addr),
        .wdata (item_reg.x),
        .re    (q_pop),
        .raddr (rd_addr),
        .rdata (above)
    );

    cnsu_ram #(.WIDTH(cnsu_pkg::PIX_W), .DEPTH(MAX_IMAGE_SIZE)) u_newer_right
    (
        .clk   (clk),
        .we    (retire),
        .waddr (wr_addr),
        .wdata (item_reg.x),
        .re    (q_pop),
        .raddr (rd_addr_right),
        .rdata (right)
    );

    cnsu_ram #(.WIDTH(cnsu_pkg::PIX_W), .DEPTH(MAX_IMAGE_SIZE)) u_older
    (
        .clk   (clk),
        .we    (retire),
        .waddr (wr_addr),
        .wdata (above),
        .re    (q_pop),
        .raddr (rd_addr),
        .rdata (up2)
    );

    assign sum      = up2 + item_reg.x + left_hold_reg + right;
    assign up_value = item_reg.cls.up_copy ? above : sum;

    assign need_up     = item_reg.cls.emit_up && !phase_reg;
    assign need_copy   = item_reg.cls.emit_copy;
    assign has_res     = need_up || need_copy;
    assign res_is_last = !(need_up && need_copy);

    assign res_push = valid_reg && has_res && !res_full;
    assign retire   = valid_reg && (!has_res || (!res_full && res_is_last));
    assign q_pop    = !q_empty && (!valid_reg || retire);

    always_comb
    begin
        if (need_up)
        begin
            res_data.row          = item_reg.row_up;
            res_data.value        = up_value;
            res_data.last_of_run  = !need_copy;
            res_data.end_of_image = 1'b0;
        end
        else
        begin
            res_data.row          = item_reg.row_cur;
            res_data.value        = item_reg.x;
            res_data.last_of_run  = 1'b1;
            res_data.end_of_image = item_reg.cls.eoi;
        end
        res_data.col = item_reg.col[cnsu_pkg::OUT_W-1:0];
    end

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (retire)
        begin
            phase_next = 1'b0;
        end
        else if (res_push)
        begin
            phase_next = 1'b1;
        end
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (retire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (retire)
        begin
            left_hold_reg <= above;
        end
    end

endmodule

>>> sv/cross_neighbour_sum_stencil_unit.sv
// top level of the cross neighbour sum stencil
//
// channel   direction  transfer when         payload
// pixel     in         push && !full         pixel_value
// result    out        pop && !empty         out_row, out_col, out_value,
//                                            last_of_run, end_of_image
// config    in         cfg_we                image_size
//
// one pixel per cycle while full is low; a last-row pixel gives two results and holds the
// back end until both are pushed, as the result queue takes one entry per cycle
// first-row pixels give no result
// reset clears counters and queues and sets the size to 256; line stores are not cleared
// a two-entry queue on each side of the back end lets either side stall on its own
module cross_neighbour_sum_stencil_unit #(
    parameter int MAX_IMAGE_SIZE = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [cnsu_pkg::PIX_W-1:0] pixel_value,
    output logic                              empty,
    input  logic                              pop,
    output logic        [cnsu_pkg::OUT_W-1:0] out_row,
    output logic        [cnsu_pkg::OUT_W-1:0] out_col,
    output logic signed [cnsu_pkg::PIX_W-1:0] out_value,
    output logic                              last_of_run,
    output logic                              end_of_image,
    input  logic                              cfg_we,
    input  logic        [cnsu_pkg::CFG_W-1:0] image_size
);

    localparam int ITEM_W = $bits(cnsu_pkg::item_t);
    localparam int RES_W  = $bits(cnsu_pkg::res_t);

    cnsu_pkg::item_t   front_item;
    cnsu_pkg::item_t   q_item;
    cnsu_pkg::res_t    res_data;
    cnsu_pkg::res_t    res_head;
    logic              front_push;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic [ITEM_W-1:0] q_rdata;
    logic [RES_W-1:0]  res_rdata;
    logic              res_push;
    logic              res_full;

    cnsu_front #(.MAX_IMAGE_SIZE(MAX_IMAGE_SIZE)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_value (pixel_value),
        .cfg_we      (cfg_we),
        .image_size  (image_size),
        .q_full      (q_full),
        .q_push      (front_push),
        .q_item      (front_item)
    );

    cnsu_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_item_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_item),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_item = cnsu_pkg::item_t'(q_rdata);

    cnsu_back #(.MAX_IMAGE_SIZE(MAX_IMAGE_SIZE)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_data)
    );

    cnsu_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .pop   (pop),
        .rdata (res_rdata),
        .full  (res_full),
        .empty (empty)
    );

    assign res_head     = cnsu_pkg::res_t'(res_rdata);
    assign out_row      = res_head.row;
    assign out_col      = res_head.col;
    assign out_value    = $signed(res_head.value);
    assign last_of_run  = res_head.last_of_run;
    assign end_of_image = res_head.end_of_image;

endmodule

>>> sv/cnsu_checker.sv
// port level checks of the stencil unit and their binding
`include "cross_neighbour_sum_stencil_unit_defines.svh"

module cnsu_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              empty,
    input logic                              pop,
    input logic        [cnsu_pkg::OUT_W-1:0] out_row,
    input logic        [cnsu_pkg::OUT_W-1:0] out_col,
    input logic signed [cnsu_pkg::PIX_W-1:0] out_value,
    input logic                              last_of_run,
    input logic                              end_of_image
);

    // no result is shown in the cycle after a reset edge
    `CNSU_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> empty, "result shown after reset")

    // the final pixel of an image closes its run
    `CNSU_ASSERT(a_eoi_last, clk, rst_n,
        (!empty && end_of_image) |-> last_of_run,
        "end of image without last of run")

    // the final pixel lies on the diagonal
    `CNSU_ASSERT(a_eoi_diag, clk, rst_n,
        (!empty && end_of_image) |-> (out_row == out_col),
        "end of image off the diagonal")

    // the second result of a run follows at once and shares the column
    `CNSU_ASSERT(a_run_pair, clk, rst_n,
        (!empty && pop && !last_of_run) |=> (!empty && out_col == $past(out_col)),
        "broken result pair")

    // a waiting result holds
    `CNSU_ASSERT(a_hold, clk, rst_n,
        (!empty && !pop) |=> (!empty && $stable(out_value) && $stable(out_row)),
        "waiting result changed")

endmodule

bind cross_neighbour_sum_stencil_unit cnsu_checker u_cnsu_checker (.*);

>>> test/testbench.sv
// self-checking testbench for the cross neighbour sum stencil unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIZE     = 1024;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 50;

    localparam logic [31:0] EXTREME_PIXELS [18] = '{
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h1234_5678, 32'h7FFF_FFFF,
        32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
        32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
        32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF
    };

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                push         = 1'b0;
    logic                full;
    logic signed [31:0]  pixel_value  = '0;
    logic                empty;
    logic                pop          = 1'b0;
    logic        [9:0]   out_row;
    logic        [9:0]   out_col;
    logic signed [31:0]  out_value;
    logic                last_of_run;
    logic                end_of_image;
    logic                cfg_we       = 1'b0;
    logic        [10:0]  image_size   = '0;

    // predictor state
    logic [31:0]         row_two_up [MAX_SIZE];
    logic [31:0]         row_one_up [MAX_SIZE];
    logic [31:0]         left_above = '0;
    logic [10:0]         size_reg   = 11'd256;
    int                  cur_row    = 0;
    int                  cur_col    = 0;

    logic [32:0]         pixel_backlog [$];
    cnsu_pkg::res_t      due_pixels [$];
    logic [32:0]         next_entry;
    cnsu_pkg::res_t      want;

    int                  send_idle_pct = 7;
    int                  take_idle_pct = 54;
    int                  fail_count    = 0;
    int                  quiet_cycles  = 0;

    cross_neighbour_sum_stencil_unit #(
        .MAX_IMAGE_SIZE(MAX_SIZE)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_value (pixel_value),
        .empty       (empty),
        .pop         (pop),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .last_of_run (last_of_run),
        .end_of_image(end_of_image),
        .cfg_we      (cfg_we),
        .image_size  (image_size)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic apply_pixel(input logic [31:0] px);
        int             n;
        int             r;
        int             c;
        logic [31:0]    above;
        bit             has_up;
        bit             has_copy;
        cnsu_pkg::res_t up_res;
        cnsu_pkg::res_t copy_res;
        n = int'(size_reg);
        if (n < 3)
            n = 3;
        if (n > MAX_SIZE)
            n = MAX_SIZE;
        r = cur_row;
        c = cur_col;
        if (c >= n)
            c = 0;
        if (r >= n)
            r = 0;
        above    = row_one_up[c];
        has_up   = (r >= 1);
        has_copy = (r == n - 1);
        if (has_up)
        begin
            up_res.row = 10'(r - 1);
            up_res.col = 10'(c);
            // borders are copied, interior takes the four neighbours
            if (r == 1 || c == 0 || c == n - 1)
                up_res.value = above;
            else
                up_res.value = row_two_up[c] + px + left_above + row_one_up[c + 1];
            up_res.last_of_run  = !has_copy;
            up_res.end_of_image = 1'b0;
            due_pixels.push_back(up_res);
        end
        if (has_copy)
        begin
            copy_res.row          = 10'(r);
            copy_res.col          = 10'(c);
            copy_res.value        = px;
            copy_res.last_of_run  = 1'b1;
            copy_res.end_of_image = (c == n - 1);
            due_pixels.push_back(copy_res);
        end
        left_above    = above;
        row_two_up[c] = above;
        row_one_up[c] = px;
        c++;
        if (c >= n)
        begin
            c = 0;
            r++;
            if (r >= n)
                r = 0;
        end
        cur_row = r;
        cur_col = c;
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    task automatic push_pixels(input int count, input bit with_pause);
        int pause_at;
        pause_at = with_pause ? int'($urandom_range(count - 1)) : -1;
        for (int i = 0; i < count; i++)
            pixel_backlog.push_back({i == pause_at, rand_pixel()});
    endtask

    task automatic settle();
        while (pixel_backlog.size() != 0 || push || due_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input logic [10:0] v);
        settle();
        @(posedge clk);
        cfg_we     <= 1'b1;
        image_size <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        size_reg  = v;
        cur_row   = 0;
        cur_col   = 0;
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push        <= 1'b0;
            pixel_value <= '0;
        end
        else
        begin
            if (push && !full)
                apply_pixel(pixel_value);
            if (!push || !full)
            begin
                // a marked pixel waits until every due result has been taken
                if (pixel_backlog.size() != 0
                    && !(pixel_backlog[0][32] && due_pixels.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    next_entry   = pixel_backlog.pop_front();
                    push        <= 1'b1;
                    pixel_value <= next_entry[31:0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (due_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: row %0d col %0d value %h last %b eoi %b",
                                 out_row, out_col, out_value, last_of_run, end_of_image);
                end
                else
                begin
                    want = due_pixels.pop_front();
                    if (want.row !== out_row || want.col !== out_col
                        || want.value !== out_value || want.last_of_run !== last_of_run
                        || want.end_of_image !== end_of_image)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected row %0d col %0d value %h last %b eoi %b,",
                                      " got row %0d col %0d value %h last %b eoi %b"},
                                     want.row, want.col, want.value, want.last_of_run,
                                     want.end_of_image, out_row, out_col, out_value,
                                     last_of_run, end_of_image);
                    end
                end
            end
            pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int side;
        int eff;
        int imgs;
        int placed;
        int pick;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: wrapping sums, border copies, two images back to back
        set_size(11'd3);
        foreach (EXTREME_PIXELS[i])
            pixel_backlog.push_back({1'b0, EXTREME_PIXELS[i]});

        // a size above the largest acts as the largest
        set_size(11'd2047);
        push_pixels(1026, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    take_idle_pct = 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    take_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                end
            endcase
            placed = 0;
            while (placed < PHASE_ITEMS)
            begin
                pick = $urandom_range(9);
                if (pick < 6)
                    side = $urandom_range(3, 7);
                else if (pick < 8)
                    side = $urandom_range(8, 16);
                else
                    side = $urandom_range(0, 2);
                eff = (side < 3) ? 3 : side;
                set_size(11'(side));
                imgs = $urandom_range(1, 3);
                for (int k = 0; k < imgs; k++)
                begin
                    push_pixels(eff * eff, $urandom_range(7) == 0);
                    placed += eff * eff;
                end
                // cut the next image short before the size changes
                if ($urandom_range(2) == 0)
                begin
                    pick = $urandom_range(1, eff * eff - 1);
                    push_pixels(pick, $urandom_range(3) == 0);
                    placed += pick;
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
